// ===== hdl/block_bitmap_allocator_assert.svh =====
// Assertion macros used by the allocator RTL.
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bba_pkg.sv =====
// Shared constants, codes and types of the block bitmap allocator.
`default_nettype none

package bba_pkg;

  localparam int MAX_BLOCKS  = 4096;
  localparam int WORD_W      = 64;
  localparam int BIT_AW      = $clog2(WORD_W);
  localparam int ROWS        = MAX_BLOCKS / WORD_W;
  localparam int ROW_AW      = $clog2(ROWS);
  localparam int BLK_W       = 12;
  localparam int CNT_W       = 13;
  localparam int BYTES_W     = 10;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam logic [OP_W-1:0] OP_NEW  = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE = 2'd2;
  localparam logic [OP_W-1:0] OP_FIND = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_BYTES = 2'd1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
  } map_req_t;

endpackage

`default_nettype wire

// ===== hdl/bba_map.sv =====
// Used/free bitmap storage: one row of WORD_W blocks per address, rows read as free until written.
`default_nettype none

module bba_map
  import bba_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire map_req_t req,
  input  wire word_t    wr_data,
  output word_t         rd_data
);

  word_t             mem [ROWS];
  word_t             rd_q_r;
  logic              rd_vld_r;
  logic [ROWS-1:0]   row_vld_r;
  logic [ROWS-1:0]   row_vld_nxt;

  always_ff @(posedge clk) begin
    rd_q_r <= mem[req.rd_addr];
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
  end

  always_comb begin
    row_vld_nxt = row_vld_r;
    if (req.wr_en) begin
      row_vld_nxt[req.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      row_vld_r <= row_vld_nxt;
      rd_vld_r  <= row_vld_r[req.rd_addr];
    end
  end

  // A row never written reads as all-free.
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire

// ===== hdl/block_bitmap_allocator.sv =====
// Top level of the first-fit block bitmap allocator.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_tvalid/in_tready   | tdata: opcode, block_number
//   out_    | output    | out_tvalid/out_tready | tdata: result_block, status
//   cfg_    | input     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// A search (new, find) scans the map one 64-block row per cycle from row 0 and
// stops at the first free block or at the end of the window; the row memory has
// a single read port. Mark and free do a row read, row write and hand-off. Reset
// is synchronous; every row reads free after reset through per-row valid flags,
// so no clearing pass is needed.
// A result waiting on out_tready holds the next one in DONE, keeping in_tready low.
`default_nettype none

module block_bitmap_allocator
  import bba_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [1:0] opcode, [13:2] block_number
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [11:0] result_block, [12] status
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  `include "block_bitmap_allocator_assert.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RMW  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] ROW_SPAN = CNT_W'(WORD_W);

  logic [1:0]         state_r, state_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [BLK_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [ROW_AW-1:0]  w_r, w_nxt;
  logic [BLK_W-1:0]   res_blk_r, res_blk_nxt;
  logic               res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BLK_W-1:0]   out_blk_r;
  logic               out_st_r;
  logic [CNT_W-1:0]   block_count_r;
  logic [BYTES_W-1:0] bitmap_bytes_r;

  logic               in_acc;
  logic [OP_W-1:0]    in_op;
  logic [BLK_W-1:0]   in_blk;
  logic               in_search;
  logic [CNT_W-1:0]   eff_count;
  logic [CNT_W-1:0]   eff_m1;
  logic [CNT_W-1:0]   bytes_bits;
  logic [CNT_W-1:0]   n_in;
  logic               blk_ok;
  logic [BLK_W-1:0]   in_idx;

  logic [CNT_W-1:0]   base;
  logic [CNT_W-1:0]   base_end;
  logic [CNT_W-1:0]   rem;
  word_t              row;
  word_t              cand_mask;
  word_t              free_bits;
  word_t              low_bit;
  logic [BIT_AW-1:0]  enc;
  logic               found;
  word_t              bit_sel;
  word_t              rmw_word;
  logic               out_load;

  map_req_t           map_req;
  word_t              map_wr_data;

  bba_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (map_req),
    .wr_data (map_wr_data),
    .rd_data (row)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r  <= CNT_MAX;
      bitmap_bytes_r <= BYTES_W'(MAX_BLOCKS / 8);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BLOCK_COUNT: begin
          block_count_r <= cfg_data;
        end
        CFG_BITMAP_BYTES: begin
          bitmap_bytes_r <= cfg_data[BYTES_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Request decode and search window at accept time.
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_op      = in_tdata[OP_W-1:0];
  assign in_blk     = in_tdata[OP_W+BLK_W-1:OP_W];
  assign in_search  = (in_op == OP_NEW) || (in_op == OP_FIND);
  assign in_idx     = in_blk - BLK_W'(1);
  assign eff_count  = (block_count_r > CNT_MAX) ? CNT_MAX : block_count_r;
  assign eff_m1     = eff_count - CNT_W'(1);
  assign bytes_bits = {bitmap_bytes_r, 3'b000};
  assign n_in       = (eff_count == '0) ? '0 :
                      ((bytes_bits < eff_m1) ? bytes_bits : eff_m1);
  assign blk_ok     = (in_blk != '0) && ({1'b0, in_blk} < eff_count);

  // Row check: candidates are bit indexes below n_r.
  assign base     = {1'b0, w_r, {BIT_AW{1'b0}}};
  assign base_end = base + ROW_SPAN;
  assign rem      = n_r - base;

  always_comb begin
    if (n_r <= base) begin
      cand_mask = '0;
    end else if (rem >= ROW_SPAN) begin
      cand_mask = '1;
    end else begin
      cand_mask = ~({WORD_W{1'b1}} << rem[BIT_AW-1:0]);
    end
  end

  assign free_bits = ~row & cand_mask;
  assign low_bit   = free_bits & (~free_bits + word_t'(1));
  assign found     = |free_bits;

  always_comb begin
    enc = '0;
    for (int j = 0; j < WORD_W; j++) begin
      enc = enc | (low_bit[j] ? BIT_AW'(j) : '0);
    end
  end

  assign bit_sel  = word_t'(1) << idx_r[BIT_AW-1:0];
  assign rmw_word = (op_r == OP_MARK) ? (row | bit_sel) : (row & ~bit_sel);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    idx_nxt         = idx_r;
    n_nxt           = n_r;
    w_nxt           = w_r;
    res_blk_nxt     = res_blk_r;
    res_st_nxt      = res_st_r;
    map_req.rd_addr = w_r + ROW_AW'(1);
    map_req.wr_en   = 1'b0;
    map_req.wr_addr = w_r;
    map_wr_data     = row | low_bit;
    unique case (state_r)
      S_IDLE: begin
        map_req.rd_addr = in_search ? '0 : in_idx[BLK_W-1:BIT_AW];
        if (in_acc) begin
          op_nxt      = in_op;
          idx_nxt     = in_idx;
          n_nxt       = n_in;
          w_nxt       = '0;
          res_blk_nxt = '0;
          res_st_nxt  = 1'b0;
          if (in_search) begin
            state_nxt = S_SCAN;
          end else if (blk_ok) begin
            state_nxt = S_RMW;
          end else begin
            res_st_nxt = 1'b1;
            state_nxt  = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          res_blk_nxt   = {w_r, enc} + BLK_W'(1);
          map_req.wr_en = (op_r == OP_NEW);
          state_nxt     = S_DONE;
        end else if (base_end >= n_r) begin
          res_st_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          w_nxt = w_r + ROW_AW'(1);
        end
      end
      S_RMW: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = idx_r[BLK_W-1:BIT_AW];
        map_wr_data     = rmw_word;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    idx_r     <= idx_nxt;
    n_r       <= n_nxt;
    w_r       <= w_nxt;
    res_blk_r <= res_blk_nxt;
    res_st_r  <= res_st_nxt;
    if (out_load) begin
      out_blk_r <= res_blk_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-BLK_W-1){1'b0}}, out_st_r, out_blk_r};

  `BBA_ASSERT_NXT(a_accept_starts_work, clk, rst_n, in_acc, state_r != S_IDLE,
    "accepted request did not leave idle")
  `BBA_ASSERT_NOW(a_write_in_work_state, clk, rst_n, map_req.wr_en,
    (state_r == S_SCAN) || (state_r == S_RMW), "map write outside scan or update")
  `BBA_ASSERT_NOW(a_scan_row_in_window, clk, rst_n, state_r == S_SCAN,
    (base < n_r) || (w_r == '0), "scan row beyond search window")
  `BBA_ASSERT_NOW(a_found_means_success, clk, rst_n,
    (state_r == S_DONE) && (res_blk_r != '0), !res_st_r, "found block with fail status")
  `BBA_ASSERT_NXT(a_done_hands_off, clk, rst_n, out_load, out_valid_r,
    "result loaded but not presented")

endmodule

`default_nettype wire
